/* rtl/core/amatt_pkg.sv */
// Shared constants, types and CORDIC angle table for the attitude block.
`timescale 1ns / 1ps
package amatt_pkg;
   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int SCALED_WIDTH = 32;
   localparam int DATA_WIDTH = 38;
   localparam int ANGLE_WIDTH = 34;
   localparam int QUEUE_DEPTH = 2;
   localparam int PROD_WIDTH = 63;
   localparam int HDIFF_WIDTH = 20;
   localparam logic [30:0] K_Q30 = 31'd1768195363;
   localparam int FULL_TURN = 36000;
   localparam int HALF_TURN = 18000;
   localparam int QUARTER_TURN = 9000;

   typedef struct packed {
      logic signed [SCALED_WIDTH-1:0] ax;
      logic signed [SCALED_WIDTH-1:0] ay;
      logic signed [SCALED_WIDTH-1:0] az;
      logic signed [SCALED_WIDTH-1:0] mx;
      logic signed [SCALED_WIDTH-1:0] my;
      logic                           my_zero;
      logic                           mx_neg;
   } sample_type;

   function automatic logic signed [ANGLE_WIDTH-1:0] atan_q16(input int i);
      logic signed [ANGLE_WIDTH-1:0] r;
      case (i)
         0: r = 34'sd294912000;
         1: r = 34'sd174096719;
         2: r = 34'sd91987925;
         3: r = 34'sd46694507;
         4: r = 34'sd23437865;
         5: r = 34'sd11730358;
         6: r = 34'sd5866610;
         7: r = 34'sd2933484;
         8: r = 34'sd1466764;
         9: r = 34'sd733385;
         10: r = 34'sd366693;
         11: r = 34'sd183346;
         12: r = 34'sd91673;
         13: r = 34'sd45837;
         14: r = 34'sd22918;
         15: r = 34'sd11459;
         16: r = 34'sd5730;
         17: r = 34'sd2865;
         18: r = 34'sd1432;
         19: r = 34'sd716;
         20: r = 34'sd358;
         21: r = 34'sd179;
         22: r = 34'sd90;
         23: r = 34'sd45;
         default: r = '0;
      endcase
      return r;
   endfunction
endpackage

/* rtl/core/amatt_front.sv */
// Front end: accept sensor words, scale and classify them, queue them for the back end.
`timescale 1ns / 1ps
module amatt_front
   import amatt_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [SAMPLE_WIDTH-1:0] req_accel_x,
   input  logic [SAMPLE_WIDTH-1:0] req_accel_y,
   input  logic [SAMPLE_WIDTH-1:0] req_accel_z,
   input  logic [SAMPLE_WIDTH-1:0] req_mag_x,
   input  logic [SAMPLE_WIDTH-1:0] req_mag_y,
   input  logic                    pop,
   output logic                    head_valid,
   output sample_type              head
);
   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SHIFT = SCALED_WIDTH - SAMPLE_WIDTH;

   sample_type    q_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   sample_type    item;
   logic          push;

   function automatic logic signed [SCALED_WIDTH-1:0] scale(input logic [SAMPLE_WIDTH-1:0] v);
      logic signed [SCALED_WIDTH-1:0] e;
      e = SCALED_WIDTH'($signed(v));
      return e <<< SHIFT;
   endfunction

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      item.ax = scale(req_accel_x);
      item.ay = scale(req_accel_y);
      item.az = scale(req_accel_z);
      item.mx = scale(req_mag_x);
      item.my = scale(req_mag_y);
      item.my_zero = (req_mag_y == '0);
      item.mx_neg = req_mag_x[SAMPLE_WIDTH-1];
   end

   assign req_ready = (count_ff != CW'(QUEUE_DEPTH));
   assign push = req_valid && req_ready;
   assign head_valid = (count_ff != '0);
   assign head = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

   property p_no_overflow;
      @(posedge clock) disable iff (reset) count_ff <= CW'(QUEUE_DEPTH);
   endproperty
   a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

   property p_pop_nonempty;
      @(posedge clock) disable iff (reset) pop |-> head_valid;
   endproperty
   a_pop_nonempty: assert property (p_pop_nonempty) else $error("pop from empty queue");

   property p_count_track;
      @(posedge clock) disable iff (reset)
         (push && !pop) |=> count_ff == $past(count_ff) + 1'b1;
   endproperty
   a_count_track: assert property (p_count_track) else $error("queue count slip");
endmodule

/* rtl/core/amatt_cordic.sv */
// Pipelined vectoring CORDIC with quadrant pre-rotation and a sideband payload.
`timescale 1ns / 1ps
module amatt_cordic
   import amatt_pkg::*;
#(
   parameter int W = DATA_WIDTH,
   parameter int ZW = ANGLE_WIDTH,
   parameter int STEPS = CORDIC_STEPS_DEF,
   parameter int SW = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [W-1:0]  in_x,
   input  logic signed [W-1:0]  in_y,
   input  logic [SW-1:0]        in_side,
   output logic                 out_valid,
   output logic signed [W-1:0]  out_x,
   output logic signed [ZW-1:0] out_z,
   output logic [SW-1:0]        out_side
);
   localparam logic signed [ZW-1:0] QUARTER_Q = ZW'(QUARTER_TURN * 65536);

   logic signed [W-1:0]  x_ff [STEPS+1];
   logic signed [W-1:0]  x_in [STEPS+1];
   logic signed [W-1:0]  y_ff [STEPS+1];
   logic signed [W-1:0]  y_in [STEPS+1];
   logic signed [ZW-1:0] z_ff [STEPS+1];
   logic signed [ZW-1:0] z_in [STEPS+1];
   logic [SW-1:0]        side_ff [STEPS+1];
   logic                 valid_ff [STEPS+1];

   assign x_in[0] = (in_x < 0) ? ((in_y >= 0) ? in_y : -in_y) : in_x;
   assign y_in[0] = (in_x < 0) ? ((in_y >= 0) ? -in_x : in_x) : in_y;
   assign z_in[0] = (in_x < 0) ? ((in_y >= 0) ? QUARTER_Q : -QUARTER_Q) : '0;

   for (genvar s = 1; s <= STEPS; s++) begin : g_step
      logic signed [W-1:0] dx, dy;
      logic                pos, neg;
      assign dx = y_ff[s-1] >>> (s - 1);
      assign dy = x_ff[s-1] >>> (s - 1);
      assign pos = (y_ff[s-1] > 0);
      assign neg = (y_ff[s-1] < 0);
      assign x_in[s] = pos ? x_ff[s-1] + dx : (neg ? x_ff[s-1] - dx : x_ff[s-1]);
      assign y_in[s] = pos ? y_ff[s-1] - dy : (neg ? y_ff[s-1] + dy : y_ff[s-1]);
      assign z_in[s] = pos ? z_ff[s-1] + atan_q16(s - 1)
                     : (neg ? z_ff[s-1] - atan_q16(s - 1) : z_ff[s-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= STEPS; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s <= STEPS; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int s = 0; s <= STEPS; s++) begin
            x_ff[s] <= x_in[s];
            y_ff[s] <= y_in[s];
            z_ff[s] <= z_in[s];
         end
         for (int s = 1; s <= STEPS; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign out_valid = valid_ff[STEPS];
   assign out_x = x_ff[STEPS];
   assign out_z = z_ff[STEPS];
   assign out_side = side_ff[STEPS];
endmodule

/* rtl/core/amatt_back.sv */
// Back end: roll, heading and pitch CORDIC pipelines, angle rounding and result register.
`timescale 1ns / 1ps
module amatt_back
   import amatt_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic signed [15:0] declination,
   input  logic               head_valid,
   input  sample_type         head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_roll_centideg,
   output logic signed [14:0] rsp_pitch_centideg,
   output logic [15:0]        rsp_heading_centideg
);
   localparam int RSW = PROD_WIDTH + 1;
   localparam int PSW = 16 + HDIFF_WIDTH;

   logic                         en;
   logic [SCALED_WIDTH-1:0]      abs_ax;
   logic [PROD_WIDTH-1:0]        prod;
   logic                         roll_valid, head_valid_c, pitch_valid;
   logic signed [DATA_WIDTH-1:0] roll_x, head_x, pitch_x;
   logic signed [ANGLE_WIDTH-1:0] roll_z, head_z, pitch_z;
   logic [RSW-1:0]               roll_side;
   logic [1:0]                   head_side;
   logic [PSW-1:0]               pitch_side_in, pitch_side;
   logic [PROD_WIDTH-1:0]        prod_rnd;
   logic signed [DATA_WIDTH-1:0] mag, ky;
   logic signed [ANGLE_WIDTH-1:0] roll_r, head_r, pitch_r;
   logic signed [15:0]           roll_c;
   logic signed [HDIFF_WIDTH-1:0] head_pre, head_diff, h1, h2, h3;
   logic signed [14:0]           pitch_c;
   logic                         valid_ff;
   logic signed [15:0]           roll_ff;
   logic signed [14:0]           pitch_ff;
   logic [15:0]                  heading_ff;

   assign en = !valid_ff || rsp_ready;
   assign pop = en && head_valid;
   assign abs_ax = head.ax[SCALED_WIDTH-1] ? SCALED_WIDTH'(-head.ax) : SCALED_WIDTH'(head.ax);
   assign prod = PROD_WIDTH'(abs_ax) * PROD_WIDTH'(K_Q30);

   amatt_cordic #(.W(DATA_WIDTH), .ZW(ANGLE_WIDTH), .STEPS(CORDIC_STEPS), .SW(RSW)) u_roll (
      .clock(clock), .reset(reset), .en(en), .in_valid(head_valid),
      .in_x(DATA_WIDTH'(head.az)), .in_y(DATA_WIDTH'(head.ay)),
      .in_side({prod, head.ax[SCALED_WIDTH-1]}),
      .out_valid(roll_valid), .out_x(roll_x), .out_z(roll_z), .out_side(roll_side)
   );

   amatt_cordic #(.W(DATA_WIDTH), .ZW(ANGLE_WIDTH), .STEPS(CORDIC_STEPS), .SW(2)) u_head (
      .clock(clock), .reset(reset), .en(en), .in_valid(head_valid),
      .in_x(DATA_WIDTH'(head.my)), .in_y(DATA_WIDTH'(head.mx)),
      .in_side({head.my_zero, head.mx_neg}),
      .out_valid(head_valid_c), .out_x(head_x), .out_z(head_z), .out_side(head_side)
   );

   always_comb begin
      prod_rnd = roll_side[RSW-1:1] + PROD_WIDTH'(64'd1 << 29);
      mag = DATA_WIDTH'(prod_rnd[PROD_WIDTH-1:30]);
      ky = roll_side[0] ? mag : -mag;
      roll_r = (roll_z + ANGLE_WIDTH'(32768)) >>> 16;
      head_r = (head_z + ANGLE_WIDTH'(32768)) >>> 16;
      if (roll_r > HALF_TURN) begin
         roll_c = 16'(HALF_TURN);
      end else if (roll_r < -HALF_TURN) begin
         roll_c = -16'(HALF_TURN);
      end else begin
         roll_c = roll_r[15:0];
      end
      if (head_side[1]) begin
         head_pre = head_side[0] ? HDIFF_WIDTH'(HALF_TURN) : '0;
      end else begin
         head_pre = head_r[HDIFF_WIDTH-1:0];
      end
      head_diff = head_pre - HDIFF_WIDTH'(declination);
      pitch_side_in = {roll_c, head_diff};
   end

   amatt_cordic #(.W(DATA_WIDTH), .ZW(ANGLE_WIDTH), .STEPS(CORDIC_STEPS), .SW(PSW)) u_pitch (
      .clock(clock), .reset(reset), .en(en), .in_valid(roll_valid && head_valid_c),
      .in_x(roll_x), .in_y(ky), .in_side(pitch_side_in),
      .out_valid(pitch_valid), .out_x(pitch_x), .out_z(pitch_z), .out_side(pitch_side)
   );

   always_comb begin
      pitch_r = (pitch_z + ANGLE_WIDTH'(32768)) >>> 16;
      if (pitch_r > QUARTER_TURN) begin
         pitch_c = 15'(QUARTER_TURN);
      end else if (pitch_r < -QUARTER_TURN) begin
         pitch_c = -15'(QUARTER_TURN);
      end else begin
         pitch_c = pitch_r[14:0];
      end
      h1 = pitch_side[HDIFF_WIDTH-1:0];
      if (h1 < 0) begin
         h2 = h1 + HDIFF_WIDTH'(FULL_TURN);
      end else begin
         h2 = h1;
      end
      if (h2 < 0) begin
         h3 = h2 + HDIFF_WIDTH'(FULL_TURN);
      end else if (h2 >= FULL_TURN) begin
         h3 = h2 - HDIFF_WIDTH'(FULL_TURN);
      end else begin
         h3 = h2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= pitch_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         roll_ff <= pitch_side[PSW-1:HDIFF_WIDTH];
         pitch_ff <= pitch_c;
         heading_ff <= h3[15:0];
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_roll_centideg = roll_ff;
   assign rsp_pitch_centideg = pitch_ff;
   assign rsp_heading_centideg = heading_ff;

   logic unused_x;
   assign unused_x = ^{head_x, pitch_x};

   property p_heading_range;
      @(posedge clock) disable iff (reset) rsp_valid |-> rsp_heading_centideg < 16'(FULL_TURN);
   endproperty
   a_heading_range: assert property (p_heading_range) else $error("heading out of range");

   property p_roll_range;
      @(posedge clock) disable iff (reset)
         rsp_valid |-> (rsp_roll_centideg <= HALF_TURN) && (rsp_roll_centideg >= -HALF_TURN);
   endproperty
   a_roll_range: assert property (p_roll_range) else $error("roll out of range");

   property p_pitch_range;
      @(posedge clock) disable iff (reset)
         rsp_valid |-> (rsp_pitch_centideg <= QUARTER_TURN) && (rsp_pitch_centideg >= -QUARTER_TURN);
   endproperty
   a_pitch_range: assert property (p_pitch_range) else $error("pitch out of range");

   property p_lanes_aligned;
      @(posedge clock) disable iff (reset) roll_valid == head_valid_c;
   endproperty
   a_lanes_aligned: assert property (p_lanes_aligned) else $error("roll and heading lanes skewed");
endmodule

/* rtl/core/accel_mag_attitude.sv */
// Top level of the accelerometer and magnetometer attitude block.
//
// Usage: present one word of accel x/y/z and mag x/y on the req_ channel
// (valid/ready). Each word yields one rsp_ word with roll and pitch in
// signed centidegrees and declination-corrected heading in [0, 36000).
// Write the declination with csr_wr_en/csr_wr_data while the block is idle.
// Throughput: one word per cycle while rsp_ready is high, set by the fully pipelined CORDIC lanes.
// Path from acceptance to rsp_valid: queue slot, roll/heading CORDIC,
// pitch CORDIC on the roll magnitude, result register.
// Reset empties the input queue and all pipeline valids and loads the
// declination with 12.02 degrees.
// When the receiver stalls, the whole back pipeline holds; the front
// queue keeps taking words until its two slots are full.
`timescale 1ns / 1ps
module accel_mag_attitude
   import amatt_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [15:0]             csr_wr_data,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [SAMPLE_WIDTH-1:0] req_accel_x,
   input  logic [SAMPLE_WIDTH-1:0] req_accel_y,
   input  logic [SAMPLE_WIDTH-1:0] req_accel_z,
   input  logic [SAMPLE_WIDTH-1:0] req_mag_x,
   input  logic [SAMPLE_WIDTH-1:0] req_mag_y,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [15:0]      rsp_roll_centideg,
   output logic signed [14:0]      rsp_pitch_centideg,
   output logic [15:0]             rsp_heading_centideg
);
   logic signed [15:0] decl_ff;
   logic               pop, head_valid;
   sample_type         head;

   always_ff @(posedge clock) begin
      if (reset) begin
         decl_ff <= 16'sd1202;
      end else if (csr_wr_en) begin
         decl_ff <= csr_wr_data;
      end
   end

   amatt_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_accel_x(req_accel_x), .req_accel_y(req_accel_y), .req_accel_z(req_accel_z),
      .req_mag_x(req_mag_x), .req_mag_y(req_mag_y),
      .pop(pop), .head_valid(head_valid), .head(head)
   );

   amatt_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
      .clock(clock), .reset(reset), .declination(decl_ff),
      .head_valid(head_valid), .head(head), .pop(pop),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_roll_centideg(rsp_roll_centideg),
      .rsp_pitch_centideg(rsp_pitch_centideg),
      .rsp_heading_centideg(rsp_heading_centideg)
   );
endmodule

/* bench/accel_mag_attitude_tb.sv */
// Self-checking bench for the attitude block: directed table, then random words vs. a predictor.
`timescale 1ns / 1ps
module accel_mag_attitude_tb
   import amatt_pkg::*;
();

   localparam int SW = 16;
   localparam int STEPS = 16;
   localparam int LATENCY = 2 * STEPS + 3;
   localparam int N_RANDOM = 630;
   localparam logic [15:0] DECL_RESET = 16'd1202;

   typedef struct packed {
      logic [SW-1:0] ax;
      logic [SW-1:0] ay;
      logic [SW-1:0] az;
      logic [SW-1:0] mx;
      logic [SW-1:0] my;
   } stim_type;

   typedef struct packed {
      logic signed [15:0] roll;
      logic signed [14:0] pitch;
      logic [15:0]        heading;
   } angles_type;

   typedef struct {
      stim_type   s;
      bit         known;
      angles_type a;
   } row_type;

   logic          clock = 0;
   logic          reset = 1;
   logic          csr_wr_en = 0;
   logic [15:0]   csr_wr_data = '0;
   logic          req_valid = 0;
   logic          req_ready;
   stim_type      req_word = '0;
   logic          rsp_valid;
   logic          rsp_ready = 0;
   angles_type    rsp_word;

   accel_mag_attitude u_dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_accel_x(req_word.ax), .req_accel_y(req_word.ay), .req_accel_z(req_word.az),
      .req_mag_x(req_word.mx), .req_mag_y(req_word.my),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_roll_centideg(rsp_word.roll), .rsp_pitch_centideg(rsp_word.pitch),
      .rsp_heading_centideg(rsp_word.heading)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   logic signed [15:0] declination;
   angles_type         pending_angles[$];
   int                 mismatches = 0;
   int                 matched = 0;
   int                 sent = 0;
   int                 hold_off = 0;
   bit                 stim_done = 0;

   function automatic longint shift_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint scale_sample(logic [SW-1:0] v);
      longint r;
      r = longint'(signed'(v));
      return r * (longint'(1) << (32 - SW));
   endfunction

   // vectoring CORDIC: angle in centidegrees, final magnitude through xo
   function automatic longint cordic_atan2(longint y, longint x, output longint xo);
      longint z, t, dx, dy;
      z = 0;
      if (x == 0 && y == 0) begin
         xo = 0;
         return 0;
      end
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y;
            y = -t;
            z = longint'(QUARTER_TURN) * 65536;
         end else begin
            x = -y;
            y = t;
            z = -longint'(QUARTER_TURN) * 65536;
         end
      end
      for (int i = 0; i < STEPS; i++) begin
         dx = shift_floor(y, i);
         dy = shift_floor(x, i);
         if (y > 0) begin
            x += dx;
            y -= dy;
            z += longint'(atan_q16(i));
         end else if (y < 0) begin
            x -= dx;
            y += dy;
            z -= longint'(atan_q16(i));
         end
      end
      xo = x;
      return shift_floor(z + 32768, 16);
   endfunction

   function automatic longint saturate(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic angles_type predict_angles(stim_type s, logic signed [15:0] decl);
      longint ax, ay, az, rmag, scratch, roll, pitch, head, ky;
      logic [63:0] mag;
      angles_type r;
      ax = scale_sample(s.ax);
      ay = scale_sample(s.ay);
      az = scale_sample(s.az);
      roll = saturate(cordic_atan2(ay, az, rmag), -HALF_TURN, HALF_TURN);
      mag = ax < 0 ? -ax : ax;
      mag = (mag * 64'(K_Q30) + (64'd1 << 29)) >> 30;
      ky = ax < 0 ? longint'(mag) : -longint'(mag);
      pitch = saturate(cordic_atan2(ky, rmag, scratch), -QUARTER_TURN, QUARTER_TURN);
      if (s.my == '0)
         head = s.mx[SW-1] ? HALF_TURN : 0;
      else
         head = cordic_atan2(scale_sample(s.mx), scale_sample(s.my), scratch);
      head -= longint'(decl);
      head %= FULL_TURN;
      if (head < 0)
         head += FULL_TURN;
      r.roll = roll[15:0];
      r.pitch = pitch[14:0];
      r.heading = head[15:0];
      return r;
   endfunction

   function automatic stim_type random_sample();
      stim_type s;
      int mode;
      s = 80'({$urandom, $urandom, $urandom});
      mode = $urandom_range(0, 9);
      if (mode == 0) s.my = '0;
      if (mode == 1) begin
         s.ay = '0;
         s.az = '0;
      end
      if (mode == 2) s.az = 16'(16'h8000 + $urandom_range(0, 3));
      if (mode == 3) begin
         s.ax = 16'($urandom_range(0, 7) - 4);
         s.ay = 16'($urandom_range(0, 7) - 4);
         s.az = 16'($urandom_range(0, 7) - 4);
         s.mx = 16'($urandom_range(0, 7) - 4);
         s.my = 16'($urandom_range(0, 7) - 4);
      end
      return s;
   endfunction

   task automatic write_declination(logic signed [15:0] v);
      @(negedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 0;
      declination = v;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      while (pending_angles.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic send_word(stim_type s, bit known, angles_type a, bit random_gap);
      int gap;
      gap = random_gap ? $urandom_range(0, 10) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_word <= s;
      req_valid <= 1;
      pending_angles.push_back(known ? a : predict_angles(s, declination));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   row_type directed[$];

   task automatic add_row(logic [SW-1:0] ax, ay, az, mx, my, bit known = 0,
                          angles_type a = '0);
      row_type v;
      v.s = {ax, ay, az, mx, my};
      v.known = known;
      v.a = a;
      directed.push_back(v);
   endtask

   initial begin
      logic signed [15:0] decl_set[$];
      declination = DECL_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // zero vector, axis-negative, mag_y zero cases: readable by eye
      add_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1,
              '{16'sd0, 15'sd0, 16'd34798});
      add_row(16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h0000, 1,
              '{16'sd18000, 15'sd0, 16'd16798});
      add_row(16'h0000, 16'h0000, 16'h0001, 16'h7FFF, 16'h0000, 1,
              '{16'sd0, 15'sd0, 16'd34798});
      add_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      add_row(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      add_row(16'h8000, 16'h0000, 16'h0000, 16'h0001, 16'hFFFF);
      add_row(16'h7FFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0001);
      add_row(16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF);
      add_row(16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h8000);
      add_row(16'h0000, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF);
      add_row(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_row(16'h1234, 16'hABCD, 16'h5555, 16'hAAAA, 16'h0F0F);
      add_row(16'hFFFF, 16'h4000, 16'hC000, 16'h4000, 16'hC000);
      add_row(16'h0001, 16'h8001, 16'h7FFF, 16'h8001, 16'h7FFF);
      add_row(16'h7FFF, 16'h0000, 16'h0000, 16'h8000, 16'h0000);
      foreach (directed[i]) send_word(directed[i].s, directed[i].known, directed[i].a, 0);
      drain();

      decl_set = '{16'sh4650, -16'sd18000, 16'sh7FFF, -16'sh8000, 16'sd0};
      foreach (decl_set[p]) begin
         write_declination(decl_set[p]);
         if (p == 1) hold_off = 80;
         repeat (N_RANDOM / 5) begin
            angles_type unused;
            send_word(random_sample(), 0, unused, $urandom_range(0, 3) != 0);
         end
         drain();
      end
      stim_done = 1;
   end

   initial begin
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            rsp_ready <= 0;
            hold_off--;
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_ready <= 0;
            repeat ($urandom_range(0, 10)) @(negedge clock);
            if (hold_off == 0) rsp_ready <= 1;
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_angles.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %p", rsp_word);
         end else begin
            angles_type want;
            want = pending_angles.pop_front();
            if (want !== rsp_word) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, got %p", want, rsp_word);
            end else begin
               matched++;
            end
         end
      end
   end

   initial begin
      wait (stim_done);
      $display("%0d words sent over six declination settings, %0d matched", sent, matched);
      if (mismatches == 0 && pending_angles.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end
endmodule
